// ===== rtl/rqnt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Requantizer package
// Register map, reset values and widths used by the requantizer module.
// ----------------------------------------------------------------------------
package rqnt_pkg;

  localparam int unsigned AccWidth   = 32;
  localparam int unsigned MultWidth  = 31;
  localparam int unsigned ShiftWidth = 5;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned DataWidth  = 32;

  typedef enum logic [2:0] {
    RegMultiplier = 3'd0,
    RegLeftShift  = 3'd1,
    RegRightShift = 3'd2,
    RegZeroPoint  = 3'd3,
    RegClampLow   = 3'd4,
    RegClampHigh  = 3'd5
  } rqnt_reg_e;

  localparam logic [MultWidth-1:0]  MultiplierReset = 31'h4000_0000;
  localparam logic [ShiftWidth-1:0] LeftShiftReset  = 5'd0;
  localparam logic [ShiftWidth-1:0] RightShiftReset = 5'd0;
  localparam logic [ByteWidth-1:0]  ZeroPointReset  = 8'd0;
  localparam logic [ByteWidth-1:0]  ClampLowReset   = 8'd0;
  localparam logic [ByteWidth-1:0]  ClampHighReset  = 8'd255;

  typedef logic signed [AccWidth-1:0]   acc_t;
  typedef logic signed [2*AccWidth-1:0] prod_t;

endpackage

// ===== rtl/rqnt_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Requantizer stream interfaces
// Valid/ready channels for the accumulator items and the output bytes.
// ----------------------------------------------------------------------------
interface rqnt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accumulator;
  logic signed [31:0] bias;

  modport source (output valid, output accumulator, output bias, input ready);
  modport sink   (input valid, input accumulator, input bias, output ready);
endinterface

interface rqnt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/int32_to_uint8_requantize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Int32 to uint8 requantizer
// Turns one accumulator plus bias into one unsigned byte per item.
//
// Items arrive on in_i (accumulator, bias) and leave on out_o (value), both
// valid/ready channels. Scale, shifts, zero point and clamp bounds are set
// through the APB port and must only be written while no item is in flight.
// The datapath is five register stages: bias add and left shift, the
// 32x32 multiply, the rounding high half, the rounding right shift, and the
// zero point add with clamp, which is also the output register. One item is
// taken every cycle while the receiver does not stall the output.
// Each stage has its own valid bit and loads whenever it is empty or its
// successor moves, so a stalled receiver holds the output register and the
// stages behind it fill up before in_i.ready drops. Nothing is lost.
// Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module int32_to_uint8_requantize
  import rqnt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rqnt_in_if.sink              in_i,
  rqnt_out_if.source           out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  localparam int unsigned NumStages = 5;

  logic [MultWidth-1:0]  multiplier_q;
  logic [ShiftWidth-1:0] left_shift_q;
  logic [ShiftWidth-1:0] right_shift_q;
  logic [ByteWidth-1:0]  zero_point_q;
  logic [ByteWidth-1:0]  clamp_low_q;
  logic [ByteWidth-1:0]  clamp_high_q;

  rqnt_reg_e reg_sel;
  logic      cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = rqnt_reg_e'(paddr[AddrWidth-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multiplier_q  <= MultiplierReset;
      left_shift_q  <= LeftShiftReset;
      right_shift_q <= RightShiftReset;
      zero_point_q  <= ZeroPointReset;
      clamp_low_q   <= ClampLowReset;
      clamp_high_q  <= ClampHighReset;
    end else if (cfg_write) begin
      unique case (reg_sel)
        RegMultiplier: multiplier_q  <= pwdata[MultWidth-1:0];
        RegLeftShift:  left_shift_q  <= pwdata[ShiftWidth-1:0];
        RegRightShift: right_shift_q <= pwdata[ShiftWidth-1:0];
        RegZeroPoint:  zero_point_q  <= pwdata[ByteWidth-1:0];
        RegClampLow:   clamp_low_q   <= pwdata[ByteWidth-1:0];
        RegClampHigh:  clamp_high_q  <= pwdata[ByteWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegMultiplier: prdata = {1'b0, multiplier_q};
      RegLeftShift:  prdata = {{(DataWidth-ShiftWidth){1'b0}}, left_shift_q};
      RegRightShift: prdata = {{(DataWidth-ShiftWidth){1'b0}}, right_shift_q};
      RegZeroPoint:  prdata = {{(DataWidth-ByteWidth){1'b0}}, zero_point_q};
      RegClampLow:   prdata = {{(DataWidth-ByteWidth){1'b0}}, clamp_low_q};
      RegClampHigh:  prdata = {{(DataWidth-ByteWidth){1'b0}}, clamp_high_q};
      default:       prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage loads when it is empty or drains.
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] stage_ready;

  always_comb begin
    stage_ready[NumStages-1] = !valid_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_ready[k] = !valid_q[k] || stage_ready[k+1];
    end
    valid_d = valid_q;
    if (stage_ready[0]) begin
      valid_d[0] = in_i.valid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (stage_ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_i.ready  = stage_ready[0];
  assign out_o.valid = valid_q[NumStages-1];

  // Stage 0: bias add and wrapping left shift.
  logic [AccWidth-1:0] sum_raw;
  acc_t                shifted_d;
  acc_t                shifted_q;

  assign sum_raw   = in_i.accumulator + in_i.bias;
  assign shifted_d = acc_t'(sum_raw << left_shift_q);

  // Stage 1: signed product with the non-negative multiplier.
  prod_t product_d;
  prod_t product_q;

  assign product_d = shifted_q * $signed({1'b0, multiplier_q});

  // Stage 2: rounding doubling high half. Adding 2^30 and an arithmetic
  // shift by 31 gives the same result as the nudge and truncating divide.
  prod_t rounded_sum;
  prod_t high_full;
  acc_t  high_d;
  acc_t  high_q;

  assign rounded_sum = product_q + prod_t'(64'sd1073741824);
  assign high_full   = rounded_sum >>> (AccWidth - 1);
  assign high_d      = high_full[AccWidth-1:0];

  // Stage 3: rounding right shift, ties away from zero.
  logic [AccWidth-1:0]      shift_mask;
  logic [AccWidth-1:0]      remainder;
  logic [AccWidth-1:0]      threshold;
  acc_t                     quotient;
  logic signed [AccWidth:0] scaled_d;
  logic signed [AccWidth:0] scaled_q;

  always_comb begin
    shift_mask = (AccWidth'(1) << right_shift_q) - AccWidth'(1);
    remainder  = high_q & shift_mask;
    threshold  = (shift_mask >> 1) + AccWidth'(high_q[AccWidth-1]);
    quotient   = high_q >>> right_shift_q;
    scaled_d   = {quotient[AccWidth-1], quotient}
                 + $signed({{AccWidth{1'b0}}, remainder > threshold});
  end

  // Stage 4: zero point and activation clamp, held as the output register.
  logic signed [AccWidth+1:0] offset_val;
  logic signed [AccWidth+1:0] low_bound;
  logic signed [AccWidth+1:0] high_bound;
  logic [ByteWidth-1:0]       value_d;
  logic [ByteWidth-1:0]       value_q;

  always_comb begin
    offset_val = {scaled_q[AccWidth], scaled_q}
                 + $signed({{(AccWidth+2-ByteWidth){1'b0}}, zero_point_q});
    low_bound  = $signed({{(AccWidth+2-ByteWidth){1'b0}}, clamp_low_q});
    high_bound = $signed({{(AccWidth+2-ByteWidth){1'b0}}, clamp_high_q});
    if (offset_val < low_bound) begin
      offset_val = low_bound;
    end
    if (offset_val > high_bound) begin
      offset_val = high_bound;
    end
    value_d = offset_val[ByteWidth-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready[0] && in_i.valid) begin
      shifted_q <= shifted_d;
    end
    if (stage_ready[1] && valid_q[0]) begin
      product_q <= product_d;
    end
    if (stage_ready[2] && valid_q[1]) begin
      high_q <= high_d;
    end
    if (stage_ready[3] && valid_q[2]) begin
      scaled_q <= scaled_d;
    end
    if (stage_ready[4] && valid_q[3]) begin
      value_q <= value_d;
    end
  end

  assign out_o.value = value_q;

  // The high half of a valid product always fits in 32 bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> (rounded_sum[2*AccWidth-1] == rounded_sum[2*AccWidth-2]))
    else $error("high half of the product overflows 32 bits");

  // An accepted item always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> valid_q[0])
    else $error("accepted item did not enter the pipeline");

  // A stalled result stays in the output register unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NumStages-1] && !out_o.ready) |=> (valid_q[NumStages-1] && $stable(value_q)))
    else $error("stalled result was lost or changed");

  // The input side only stalls when every stage holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (valid_q == {NumStages{1'b1}}))
    else $error("input stalled while the pipeline had room");

endmodule
